### hdl/fmbq_pkg.sv
// Package with the types, codes and sizes shared by the front/middle/back queue.
`default_nettype none

package fmbq_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT  = 3'd0,
        OP_PUSH_MIDDLE = 3'd1,
        OP_PUSH_BACK   = 3'd2,
        OP_POP_FRONT   = 3'd3,
        OP_POP_MIDDLE  = 3'd4,
        OP_POP_BACK    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam word_t NONE_VALUE = '1;

    typedef struct packed {
        logic [2:0] opcode;
        word_t      value;
    } req_t;

    typedef struct packed {
        word_t            result_value;
        logic [1:0]       status;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        word_t     new_value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### hdl/front_middle_back_queue.sv
// Top level of the bounded queue with push and pop at its front, middle and back.
// The queue holds up to CAPACITY signed 32-bit entries in a row of cells, entry 0 at the
// front. It accepts one operation per clock cycle, and the result of each transaction is
// registered and offered in the cycle after acceptance; a new request is taken while the
// result register is empty or being emptied. The rate is set by the cell row, in which
// every operation moves each cell by at most one position. Push middle
// inserts at index floor(n/2), pop middle removes index floor((n-1)/2). A push on a full
// queue is dropped with status full, a pop on an empty queue returns -1 with status empty,
// and unused opcodes leave the queue unchanged with status ok.
`default_nettype none

module front_middle_back_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire fmbq_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output fmbq_pkg::rsp_t      rsp
);

    localparam int N = fmbq_pkg::CAPACITY;

    fmbq_pkg::cnt_t  count_reg;
    fmbq_pkg::cnt_t  count_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    fmbq_pkg::rsp_t  rsp_reg;
    fmbq_pkg::rsp_t  rsp_next;

    logic            req_fire;
    logic            is_push;
    logic            is_pop;
    logic            full;
    logic            empty;
    logic            do_ins;
    logic            do_rem;
    fmbq_pkg::cnt_t  pos;
    fmbq_pkg::word_t popped;

    fmbq_pkg::word_t    cell_data [N];
    fmbq_pkg::word_t    cell_hit  [N];
    fmbq_pkg::cell_ctrl_t cell_ctrl [N];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign req_fire  = req_valid && !req_stall;

    assign is_push = (req.opcode == fmbq_pkg::OP_PUSH_FRONT)
                  || (req.opcode == fmbq_pkg::OP_PUSH_MIDDLE)
                  || (req.opcode == fmbq_pkg::OP_PUSH_BACK);
    assign is_pop  = (req.opcode == fmbq_pkg::OP_POP_FRONT)
                  || (req.opcode == fmbq_pkg::OP_POP_MIDDLE)
                  || (req.opcode == fmbq_pkg::OP_POP_BACK);

    assign full   = (count_reg == fmbq_pkg::CNT_W'(N));
    assign empty  = (count_reg == '0);
    assign do_ins = req_fire && is_push && !full;
    assign do_rem = req_fire && is_pop && !empty;

    always_comb
    begin
        unique case (req.opcode)
            fmbq_pkg::OP_PUSH_FRONT:  pos = '0;
            fmbq_pkg::OP_PUSH_MIDDLE: pos = count_reg >> 1;
            fmbq_pkg::OP_PUSH_BACK:   pos = count_reg;
            fmbq_pkg::OP_POP_FRONT:   pos = '0;
            fmbq_pkg::OP_POP_MIDDLE:  pos = (count_reg - 1'b1) >> 1;
            fmbq_pkg::OP_POP_BACK:    pos = count_reg - 1'b1;
            default:                  pos = '0;
        endcase
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        localparam fmbq_pkg::cnt_t IDX = fmbq_pkg::CNT_W'(i);

        always_comb
        begin
            cell_ctrl[i].new_value = req.value;
            priority if (do_ins && (IDX == pos))
                cell_ctrl[i].cmd = fmbq_pkg::CELL_LOAD;
            else if (do_ins && (IDX > pos))
                cell_ctrl[i].cmd = fmbq_pkg::CELL_FROM_LEFT;
            else if (do_rem && (IDX >= pos))
                cell_ctrl[i].cmd = fmbq_pkg::CELL_FROM_RIGHT;
            else
                cell_ctrl[i].cmd = fmbq_pkg::CELL_HOLD;
        end

        assign cell_hit[i] = (IDX == pos) ? cell_data[i] : '0;

        fmbq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .left_data  ((i == 0) ? req.value : cell_data[(i == 0) ? 0 : i - 1]),
            .right_data ((i == N - 1) ? cell_data[i] : cell_data[(i == N - 1) ? i : i + 1]),
            .data       (cell_data[i])
        );
    end

    always_comb
    begin
        popped = '0;
        for (int k = 0; k < N; k++)
        begin
            popped = popped | cell_hit[k];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rem)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        rsp_next.result_value = do_rem ? popped : fmbq_pkg::NONE_VALUE;
        priority if (is_push && full)
            rsp_next.status = fmbq_pkg::ST_FULL;
        else if (is_pop && empty)
            rsp_next.status = fmbq_pkg::ST_EMPTY;
        else
            rsp_next.status = fmbq_pkg::ST_OK;
        rsp_next.entry_count = fmbq_pkg::COUNT_W'(count_next);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (req_fire)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fmbq_pkg::CNT_W'(N))
        else $error("queue count exceeds capacity");

    a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !req_fire |=> $stable(count_reg))
        else $error("queue count changed without a transaction");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && is_pop && empty) |=>
            (rsp_valid && (rsp.status == fmbq_pkg::ST_EMPTY)
             && (rsp.result_value == fmbq_pkg::NONE_VALUE)))
        else $error("pop on empty queue not reported as empty");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && is_push && full) |=>
            (rsp_valid && (rsp.status == fmbq_pkg::ST_FULL) && $stable(count_reg)))
        else $error("push on full queue not dropped");

endmodule

`default_nettype wire

### hdl/fmbq_cell.sv
// One storage cell of the queue row, loading, holding or shifting from a neighbor.
`default_nettype none

module fmbq_cell (
    input  wire logic                clk,
    input  wire fmbq_pkg::cell_ctrl_t ctrl,
    input  wire fmbq_pkg::word_t     left_data,
    input  wire fmbq_pkg::word_t     right_data,
    output fmbq_pkg::word_t          data
);

    fmbq_pkg::word_t data_reg;
    fmbq_pkg::word_t data_next;

    always_comb
    begin
        unique case (ctrl.cmd)
            fmbq_pkg::CELL_HOLD:       data_next = data_reg;
            fmbq_pkg::CELL_LOAD:       data_next = ctrl.new_value;
            fmbq_pkg::CELL_FROM_LEFT:  data_next = left_data;
            fmbq_pkg::CELL_FROM_RIGHT: data_next = right_data;
            default:                   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire
